[rtl/bitmap_page_allocator_defines.svh]
`ifndef BITMAP_PAGE_ALLOCATOR_DEFINES_SVH
`define BITMAP_PAGE_ALLOCATOR_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define BPA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bitmap page allocator check failed");

// next-cycle implication, sampled on clk, off during reset
`define BPA_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bitmap page allocator check failed");

`endif

[rtl/bpa_pkg.sv]
`default_nettype none

package bpa_pkg;

  localparam int CNT_W     = 13;
  localparam int ADDR_W    = 32;
  localparam int OP_W      = 2;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 2;

  // defaults for the top level parameters
  localparam int unsigned MAX_PAGES_DEF  = 4096;
  localparam int unsigned PAGE_BYTES_DEF = 4096;

  // first managed byte address
  localparam logic [ADDR_W-1:0] BASE_ADDRESS = 32'h0010_0000;

  // register reset values
  localparam logic [CNT_W-1:0] MEMORY_PAGES_RST   = 13'd2560;
  localparam logic [CNT_W-1:0] RESERVED_PAGES_RST = 13'd256;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MEMORY_PAGES   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RESERVED_PAGES = 2'd1;

  // operation codes
  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
  localparam logic [OP_W-1:0] OP_INIT  = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] STATUS_OK          = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_OOM         = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_DOUBLE_FREE = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_RANGE       = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [ADDR_W-1:0] page_address;
  } bpa_request_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   alloc_address;
    logic [CNT_W-1:0]    free_count;
    logic [CNT_W-1:0]    total_count;
  } bpa_result_t;

endpackage

`default_nettype wire

[rtl/bitmap_page_allocator.sv]
// channel   direction  handshake               payload
// request   in         start & !busy           bpa_request_t (op, page_address)
// result    out        done, one cycle         bpa_result_t (status, address, counts)
// config    in         cfg_valid & cfg_ready   cfg_index, cfg_data
//
// init rewrites the bitmap ram one word per cycle
// alloc scans the bitmap ram, one ram word read per cycle
// free finds the page index by shift, then does a ram read and a ram write
// reset is synchronous; the map needs no clearing, no page is managed until init
// results cannot be stalled; a new request may start in the cycle done is high
`default_nettype none

module bitmap_page_allocator
  import bpa_pkg::*;
#(
  parameter int unsigned MAX_PAGES  = MAX_PAGES_DEF,
  parameter int unsigned PAGE_BYTES = PAGE_BYTES_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire bpa_request_t         request,
  output logic                      done,
  output bpa_result_t               result,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CNT_W-1:0]     cfg_data
);

  localparam int MAP_WORDS = (MAX_PAGES + 31) / 32;
  localparam int WORD_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int PI_W      = WORD_W + 5;
  // page size must be a power of two, which the block does not enforce; the page index is a shift
  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam logic [WORD_W-1:0] LAST_MAP_WORD = WORD_W'(MAP_WORDS - 1);

  // sequencer states
  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_INIT     = 6'b000010,
    S_SCAN     = 6'b000100,
    S_ADDR     = 6'b001000,
    S_FREE_RD  = 6'b010000,
    S_FREE_CHK = 6'b100000
  } state_t;

  state_t state;

  // configuration registers
  logic [CNT_W-1:0] memory_pages;
  logic [CNT_W-1:0] reserved_pages;

  // allocator state
  logic [CNT_W-1:0] free_total;
  logic [CNT_W-1:0] managed_total;

  // bitmap ram, one bit per page, 1 = used
  logic [31:0]       map_mem [MAP_WORDS];
  logic [31:0]       rdata;
  logic              mem_re;
  logic              mem_we;
  logic [WORD_W-1:0] raddr;
  logic [WORD_W-1:0] waddr;
  logic [31:0]       wdata;

  // word walker shared by init and alloc scan
  logic [WORD_W-1:0] wcnt;
  logic [WORD_W-1:0] last_word;
  logic [WORD_W-1:0] chk_word;
  logic              chk_valid;
  logic              issue_done;

  // init bounds latched at start
  logic [CNT_W-1:0] init_total;
  logic [CNT_W-1:0] init_res;

  // page index of a free request
  logic [31:0]   quo;

  logic [PI_W-1:0]     found_idx;
  logic [STATUS_W-1:0] res_status;
  logic [ADDR_W-1:0]   res_addr;

  // combinational helpers
  logic [31:0]      init_word;
  logic [4:0]       sel;
  logic             scan_free;
  logic             scan_last;
  logic             free_bit;
  logic             in_range;
  logic [CNT_W-1:0] mem_clamp;
  logic [CNT_W-1:0] res_clamp;
  logic [31:0]      tot_m1;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  // counts come from the live registers; they cannot move during the done cycle
  assign result = '{status:        res_status,
                    alloc_address: res_addr,
                    free_count:    free_total,
                    total_count:   managed_total};

  // init pattern for the current word: free only for reserve <= page < total
  always_comb begin
    logic [31:0] pg;
    pg = '0;
    for (int b = 0; b < 32; b++) begin
      pg = (32'(wcnt) << 5) | 32'(b);
      init_word[b] = !((pg >= 32'(init_res)) && (pg < 32'(init_total)));
    end
  end

  // lowest clear bit of the word under check
  always_comb begin
    sel = '0;
    for (int b = 31; b >= 0; b--) begin
      if (!rdata[b]) begin
        sel = 5'(b);
      end
    end
  end

  assign scan_free = chk_valid && (rdata != '1);
  assign scan_last = chk_valid && (chk_word == last_word);
  assign free_bit  = rdata[quo[4:0]];
  assign in_range  = (quo < 32'(managed_total));

  // init clamps
  assign mem_clamp = (32'(memory_pages) > 32'(MAX_PAGES)) ? CNT_W'(MAX_PAGES) : memory_pages;
  assign res_clamp = (reserved_pages > mem_clamp) ? mem_clamp : reserved_pages;
  assign tot_m1    = 32'(managed_total) - 32'd1;

  // ram port control
  always_comb begin
    mem_re = 1'b0;
    mem_we = 1'b0;
    raddr  = quo[5 +: WORD_W];
    waddr  = quo[5 +: WORD_W];
    wdata  = rdata & ~(32'd1 << quo[4:0]);
    case (state)
      S_INIT: begin
        mem_we = 1'b1;
        waddr  = wcnt;
        wdata  = init_word;
      end
      S_SCAN: begin
        raddr  = wcnt;
        waddr  = chk_word;
        wdata  = rdata | (32'd1 << sel);
        mem_we = scan_free;
        mem_re = !scan_free && !scan_last && !issue_done;
      end
      S_FREE_RD: begin
        mem_re = in_range;
      end
      S_FREE_CHK: begin
        mem_we = free_bit;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      map_mem[waddr] <= wdata;
    end
    if (mem_re) begin
      rdata <= map_mem[raddr];
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      memory_pages   <= MEMORY_PAGES_RST;
      reserved_pages <= RESERVED_PAGES_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MEMORY_PAGES:   memory_pages   <= cfg_data;
        REG_RESERVED_PAGES: reserved_pages <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      done          <= 1'b0;
      free_total    <= '0;
      managed_total <= '0;
      chk_valid     <= 1'b0;
      issue_done    <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            res_addr <= '0;
            case (request.op)
              OP_ALLOC: begin
                if (managed_total == '0) begin
                  res_status <= STATUS_OOM;
                  done       <= 1'b1;
                end else begin
                  wcnt       <= '0;
                  chk_valid  <= 1'b0;
                  issue_done <= 1'b0;
                  last_word  <= tot_m1[5 +: WORD_W];
                  state      <= S_SCAN;
                end
              end
              OP_FREE: begin
                if (request.page_address < BASE_ADDRESS) begin
                  res_status <= STATUS_RANGE;
                  done       <= 1'b1;
                end else begin
                  quo   <= (request.page_address - BASE_ADDRESS) >> PAGE_SHIFT;
                  state <= S_FREE_RD;
                end
              end
              OP_INIT: begin
                init_total <= mem_clamp;
                init_res   <= res_clamp;
                wcnt       <= '0;
                state      <= S_INIT;
              end
              default: begin
                // unused code: counts only
                res_status <= STATUS_OK;
                done       <= 1'b1;
              end
            endcase
          end
        end
        S_INIT: begin
          if (wcnt == LAST_MAP_WORD) begin
            managed_total <= init_total;
            free_total    <= init_total - init_res;
            res_status    <= STATUS_OK;
            done          <= 1'b1;
            state         <= S_IDLE;
          end else begin
            wcnt <= wcnt + 1'b1;
          end
        end
        S_SCAN: begin
          if (scan_free) begin
            found_idx  <= {chk_word, sel};
            free_total <= free_total - 1'b1;
            state      <= S_ADDR;
          end else if (scan_last) begin
            res_status <= STATUS_OOM;
            done       <= 1'b1;
            state      <= S_IDLE;
          end else if (!issue_done) begin
            chk_word  <= wcnt;
            chk_valid <= 1'b1;
            if (wcnt == last_word) begin
              issue_done <= 1'b1;
            end else begin
              wcnt <= wcnt + 1'b1;
            end
          end else begin
            chk_valid <= 1'b0;
          end
        end
        S_ADDR: begin
          // address wraps modulo 2^32
          res_addr   <= BASE_ADDRESS + 32'(found_idx) * 32'(PAGE_BYTES);
          res_status <= STATUS_OK;
          done       <= 1'b1;
          state      <= S_IDLE;
        end
        S_FREE_RD: begin
          if (!in_range) begin
            res_status <= STATUS_RANGE;
            done       <= 1'b1;
            state      <= S_IDLE;
          end else begin
            state <= S_FREE_CHK;
          end
        end
        S_FREE_CHK: begin
          if (!free_bit) begin
            res_status <= STATUS_DOUBLE_FREE;
          end else begin
            res_status <= STATUS_OK;
            free_total <= free_total + 1'b1;
          end
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/bpa_checker.sv]
`default_nettype none
`include "bitmap_page_allocator_defines.svh"

module bpa_checker
  import bpa_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        done,
  input wire bpa_result_t result
);

  // an address only comes with a good status
  `BPA_ASSERT_IMP(a_addr_only_ok, done && (result.status != STATUS_OK), result.alloc_address == 32'd0)

  // free pages never exceed managed pages
  `BPA_ASSERT_IMP(a_free_le_total, done, result.free_count <= result.total_count)

  // an accepted request either keeps the block busy or finishes at once
  `BPA_ASSERT_NXT(a_accept_progress, start && !busy, busy || done)

  // no result without a request in flight
  `BPA_ASSERT_IMP(a_done_caused, done, $past(busy) || $past(start))

endmodule

bind bitmap_page_allocator bpa_checker u_bpa_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

`default_nettype wire
